// File: rtl/lrfu_pkg.sv
// Shared types, constants and the decay table of the LRFU replacement core.
`timescale 1ns / 1ps
`default_nettype none
package lrfu_pkg;

   localparam int ENTRIES          = 64;
   localparam int SLOT_W           = 6;
   localparam int CNT_W            = 7;
   localparam int CRF_W            = 24;
   localparam int TIME_W           = 32;
   localparam int DECAY_TABLE_BITS = 8;
   localparam int DTAB_W           = 17;
   localparam int DECAY_PERIOD     = 10000;
   localparam int REM_W            = 14;
   localparam int KQ_W             = 19;
   localparam int MUL_W            = 32;
   // reciprocal of 10000: exact quotient for any 32-bit dividend
   localparam logic [MUL_W-1:0] DIV_MAGIC = 32'hD1B71759;
   localparam int DIV_SHIFT        = 45;
   localparam logic [CRF_W-1:0] CRF_ONE = 24'h010000;
   localparam logic [CRF_W-1:0] CRF_MAX = 24'hFFFFFF;

   localparam logic TIER_PROT = 1'b0;
   localparam logic TIER_FIFO = 1'b1;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REF    = 2'd1,
      MODE_ERASE  = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REF_RD,
      ST_REF_GO,
      ST_REF_WAIT,
      ST_DEMOTE,
      ST_INS,
      ST_PROMO,
      ST_EV_FIFO,
      ST_EV_PROT,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_K,
      PH_F,
      PH_J,
      PH_MUL,
      PH_SHF,
      PH_ADD
   } phase_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] idx;
   } scan_res_type;

   typedef struct packed {
      logic             done;
      logic [CRF_W-1:0] crf;
   } decay_res_type;

   typedef logic [DTAB_W-1:0] dtab_type [2**DECAY_TABLE_BITS];

   // integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_q;
      v     = v_in;
      res   = '0;
      bit_q = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (bit_q > v) bit_q = bit_q >> 2;
      end
      for (int n = 0; n < 32; n++) begin
         if (bit_q != 0) begin
            if (v >= res + bit_q) begin
               v   = v - (res + bit_q);
               res = (res >> 1) + bit_q;
            end else begin
               res = res >> 1;
            end
            bit_q = bit_q >> 2;
         end
      end
      return res;
   endfunction

   // 2^(-j/2^B) in Q1.16, from repeated square roots of one half
   function automatic dtab_type build_dtab();
      dtab_type    tab;
      logic [63:0] roots [DECAY_TABLE_BITS+1];
      logic [63:0] t;
      logic [63:0] e;
      roots[0] = '0;
      roots[1] = isqrt64(64'd1 << 63);
      for (int m = 1; m < DECAY_TABLE_BITS; m++) begin
         roots[m+1] = isqrt64(roots[m] << 32);
      end
      for (int j = 0; j < 2**DECAY_TABLE_BITS; j++) begin
         t = 64'd1 << 32;
         for (int i = 0; i < DECAY_TABLE_BITS; i++) begin
            if (((j >> i) & 1) != 0)
               t = (t * roots[DECAY_TABLE_BITS-i] + (64'd1 << 31)) >> 32;
         end
         e = (t + 64'd32768) >> 16;
         tab[j] = e[DTAB_W-1:0];
      end
      return tab;
   endfunction

   localparam dtab_type DECAY_TAB = build_dtab();

endpackage
`default_nettype wire

// File: rtl/lrfu_decay.sv
// Iterative CRF decay unit: one shared multiplier for divide, table product, then shift and add.
`timescale 1ns / 1ps
`default_nettype none
module lrfu_decay (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lrfu_pkg::TIME_W-1:0] dt,
   input  wire logic [lrfu_pkg::CRF_W-1:0]  crf,
   output lrfu_pkg::decay_res_type          res
);
   import lrfu_pkg::*;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   phase_type                   phase_ff, phase_in;
   logic [TIME_W-1:0]           dt_ff, dt_in;
   logic [CRF_W-1:0]            crf_ff, crf_in;
   logic [KQ_W-1:0]             k_ff, k_in;
   logic [2*MUL_W-1:0]          prod_ff, prod_in;
   logic [CRF_W:0]              sh_ff, sh_in;
   logic [CRF_W-1:0]            out_ff, out_in;
   logic [MUL_W-1:0]            mul_a, mul_b;
   logic [2*MUL_W-1:0]          mul_p;
   logic [TIME_W-1:0]           f_full;
   logic [REM_W-1:0]            f;
   logic [DECAY_TABLE_BITS-1:0] j;
   logic                        k_big;
   logic [CRF_W+1:0]            sum;

   // the shared multiplier
   assign mul_p  = mul_a * mul_b;
   assign f_full = dt_ff - prod_ff[TIME_W-1:0];
   assign f      = f_full[REM_W-1:0];
   assign j      = prod_ff[DIV_SHIFT +: DECAY_TABLE_BITS];
   assign k_big  = (|k_ff[KQ_W-1:5]) || (k_ff[4:0] >= 5'd24);
   assign sum    = {1'b0, sh_ff} + {2'b00, CRF_ONE};

   // k = dt / 10000 by reciprocal, f = dt - k * 10000, j = (f << B) / 10000,
   // then the table product, shift by k and saturating add of one
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      dt_in    = dt_ff;
      crf_in   = crf_ff;
      k_in     = k_ff;
      prod_in  = prod_ff;
      sh_in    = sh_ff;
      out_in   = out_ff;
      mul_a    = dt_ff;
      mul_b    = DIV_MAGIC;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_K;
         dt_in    = dt;
         crf_in   = crf;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_K: begin
               mul_a    = dt_ff;
               mul_b    = DIV_MAGIC;
               prod_in  = mul_p;
               phase_in = PH_F;
            end
            PH_F: begin
               k_in     = prod_ff[DIV_SHIFT +: KQ_W];
               mul_a    = MUL_W'(prod_ff[DIV_SHIFT +: KQ_W]);
               mul_b    = MUL_W'(DECAY_PERIOD);
               prod_in  = mul_p;
               phase_in = PH_J;
            end
            PH_J: begin
               mul_a    = {{(MUL_W-REM_W-DECAY_TABLE_BITS){1'b0}}, f,
                           {DECAY_TABLE_BITS{1'b0}}};
               mul_b    = DIV_MAGIC;
               prod_in  = mul_p;
               phase_in = PH_MUL;
            end
            PH_MUL: begin
               mul_a    = MUL_W'(crf_ff);
               mul_b    = MUL_W'(DECAY_TAB[j]);
               prod_in  = mul_p;
               phase_in = PH_SHF;
            end
            PH_SHF: begin
               sh_in    = k_big ? '0 : (prod_ff[CRF_W+16:16] >> k_ff[4:0]);
               phase_in = PH_ADD;
            end
            PH_ADD: begin
               out_in  = (sum > {2'b00, CRF_MAX}) ? CRF_MAX : sum[CRF_W-1:0];
               done_in = 1'b1;
               busy_in = 1'b0;
            end
            default: phase_in = PH_K;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_K;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      dt_ff   <= dt_in;
      crf_ff  <= crf_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      out_ff  <= out_in;
   end

   assign res.done = done_ff;
   assign res.crf  = out_ff;

endmodule
`default_nettype wire

// File: rtl/lrfu_scan.sv
// Sequential scan over all slots: lowest-CRF protected entry or FIFO front.
`timescale 1ns / 1ps
`default_nettype none
module lrfu_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        kind,
   input  wire logic [lrfu_pkg::ENTRIES-1:0] valid_vec,
   input  wire logic                        tier_rd,
   input  wire logic [lrfu_pkg::CRF_W-1:0]  crf_rd,
   input  wire logic [lrfu_pkg::TIME_W-1:0] order_rd,
   input  wire logic [lrfu_pkg::TIME_W-1:0] cnt,
   output logic [lrfu_pkg::SLOT_W-1:0]      rd_addr,
   output lrfu_pkg::scan_res_type           res
);
   import lrfu_pkg::*;

   logic                busy_ff, busy_in;
   logic                kind_ff, kind_in;
   logic [SLOT_W:0]     idx_ff, idx_in;
   logic                chk_ff, chk_in;
   logic [SLOT_W-1:0]   idxd_ff, idxd_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic [CRF_W-1:0]    bcrf_ff, bcrf_in;
   logic [TIME_W-1:0]   bage_ff, bage_in;
   logic [TIME_W-1:0]   age;
   logic                cand, better, done;

   assign age  = cnt - order_rd;
   assign cand = chk_ff && valid_vec[idxd_ff] && (tier_rd == kind_ff);
   assign better = (kind_ff == TIER_PROT) ?
                   ((crf_rd < bcrf_ff) || ((crf_rd == bcrf_ff) && (age > bage_ff))) :
                   (age > bage_ff);
   assign done = busy_ff && idx_ff[SLOT_W] && !chk_ff;

   // issue one address a cycle, compare the registered read of it in the next cycle
   always_comb begin
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      chk_in   = 1'b0;
      idxd_in  = idx_ff[SLOT_W-1:0];
      found_in = found_ff;
      best_in  = best_ff;
      bcrf_in  = bcrf_ff;
      bage_in  = bage_ff;
      if (start) begin
         busy_in  = 1'b1;
         kind_in  = kind;
         idx_in   = '0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (!idx_ff[SLOT_W]) begin
            idx_in = idx_ff + 1'b1;
            chk_in = 1'b1;
         end
         if (cand && (!found_ff || better)) begin
            found_in = 1'b1;
            best_in  = idxd_ff;
            bcrf_in  = crf_rd;
            bage_in  = age;
         end
         if (done) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         chk_ff   <= 1'b0;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         chk_ff   <= chk_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
      kind_ff <= kind_in;
      idxd_ff <= idxd_in;
      best_ff <= best_in;
      bcrf_ff <= bcrf_in;
      bage_ff <= bage_in;
   end

   assign rd_addr   = idx_ff[SLOT_W-1:0];
   assign res.busy  = busy_ff;
   assign res.done  = done;
   assign res.found = found_ff;
   assign res.idx   = best_ff;

endmodule
`default_nettype wire

// File: rtl/lrfu_cache_replacement_core.sv
// LRFU replacement core: sequencer, entry memories, valid bits and result register.
// Requests are taken one at a time. An ignored request or an erase goes straight
// to the result, an insert without demotion or eviction writes the entry first.
// Every search for the lowest-CRF protected entry or the FIFO front is one pass of
// the shared scan unit over all 64 slots: an insert at capacity adds one pass for
// the demotion, and each eviction takes one pass (two when the FIFO tier is empty).
// A reference reads the entry, runs the decay unit, whose one multiplier is used
// three times for the divide by 10000 and once for the table product, and adds
// one scan pass when a FIFO entry is promoted. Evictions come out one result per
// pass; a stalled result channel holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lrfu_cache_replacement_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: mode[1:0], slot[7:2], time_ms[39:8]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // result: evict_valid[0], evict_slot[6:1], status[7]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   // register write: 0 capacity_limit, 1 protected_threshold
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);
   import lrfu_pkg::*;

   localparam logic CSR_CAP = 1'b0;
   localparam logic CSR_THR = 1'b1;

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [TIME_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cap_ff, thr_ff;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic                ins_tier_ff, ins_tier_in;
   logic                ref_fifo_ff, ref_fifo_in;
   logic                res_ev_ff, res_ev_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                res_st_ff, res_st_in;
   logic                res_last_ff, res_last_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]          rsp_tdata_ff, rsp_tdata_in;
   logic                rsp_tlast_ff, rsp_tlast_in;

   // entry memories
   logic                tier_mem  [ENTRIES];
   logic [CRF_W-1:0]    crf_mem   [ENTRIES];
   logic [TIME_W-1:0]   time_mem  [ENTRIES];
   logic [TIME_W-1:0]   order_mem [ENTRIES];
   logic                tier_rd_ff;
   logic [CRF_W-1:0]    crf_rd_ff;
   logic [TIME_W-1:0]   time_rd_ff;
   logic [TIME_W-1:0]   order_rd_ff;
   logic [SLOT_W-1:0]   mem_addr;
   logic                tier_we, order_we, crf_we, time_we;
   logic [SLOT_W-1:0]   tier_wa, order_wa;
   logic                tier_wd;
   logic [CRF_W-1:0]    crf_wd;

   logic                scan_start, scan_kind;
   logic [SLOT_W-1:0]   scan_addr;
   scan_res_type        scan_res;
   logic                decay_start;
   decay_res_type       decay_res;

   mode_type            req_mode;
   logic [SLOT_W-1:0]   req_slot;
   logic                accept, ignore;
   logic [CNT_W-1:0]    occ_dec;

   assign req_mode = mode_type'(req_tdata[1:0]);
   assign req_slot = req_tdata[7:2];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign ignore = (req_mode != MODE_INSERT && req_mode != MODE_REF && req_mode != MODE_ERASE) ||
                   ((req_mode == MODE_INSERT) && valid_ff[req_slot]) ||
                   ((req_mode != MODE_INSERT) && !valid_ff[req_slot]);
   assign occ_dec = occ_ff - 1'b1;
   assign mem_addr = scan_res.busy ? scan_addr : slot_ff;
   assign csr_ready = 1'b1;

   lrfu_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .kind      (scan_kind),
      .valid_vec (valid_ff),
      .tier_rd   (tier_rd_ff),
      .crf_rd    (crf_rd_ff),
      .order_rd  (order_rd_ff),
      .cnt       (cnt_ff),
      .rd_addr   (scan_addr),
      .res       (scan_res)
   );

   lrfu_decay u_decay (
      .clock (clock),
      .reset (reset),
      .start (decay_start),
      .dt    (now_ff - time_rd_ff),
      .crf   (crf_rd_ff),
      .res   (decay_res)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      slot_in     = slot_ff;
      now_in      = now_ff;
      occ_in      = occ_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      ins_tier_in = ins_tier_ff;
      ref_fifo_in = ref_fifo_ff;
      res_ev_in   = res_ev_ff;
      res_slot_in = res_slot_ff;
      res_st_in   = res_st_ff;
      res_last_in = res_last_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      scan_start  = 1'b0;
      scan_kind   = TIER_PROT;
      decay_start = 1'b0;
      tier_we     = 1'b0;
      tier_wa     = slot_ff;
      tier_wd     = TIER_PROT;
      order_we    = 1'b0;
      order_wa    = slot_ff;
      crf_we      = 1'b0;
      crf_wd      = CRF_ONE;
      time_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in     = req_mode;
               slot_in     = req_slot;
               now_in      = req_tdata[39:8];
               res_ev_in   = 1'b0;
               res_slot_in = '0;
               res_st_in   = 1'b0;
               res_last_in = 1'b1;
               if (ignore) begin
                  res_st_in = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  case (req_mode)
                     MODE_INSERT: begin
                        occ_in = occ_ff + 1'b1;
                        if (occ_ff == cap_ff) begin
                           ins_tier_in = TIER_PROT;
                           scan_start  = 1'b1;
                           state_in    = ST_DEMOTE;
                        end else begin
                           ins_tier_in = (occ_in > thr_ff) ? TIER_FIFO : TIER_PROT;
                           state_in    = ST_INS;
                        end
                     end
                     MODE_REF: state_in = ST_REF_RD;
                     default: begin
                        valid_in[req_slot] = 1'b0;
                        if (occ_ff != '0) occ_in = occ_dec;
                        state_in = ST_OUT;
                     end
                  endcase
               end
            end
         end
         ST_REF_RD: state_in = ST_REF_GO;
         ST_REF_GO: begin
            decay_start = 1'b1;
            ref_fifo_in = tier_rd_ff;
            state_in    = ST_REF_WAIT;
         end
         ST_REF_WAIT: begin
            if (decay_res.done) begin
               crf_we  = 1'b1;
               crf_wd  = decay_res.crf;
               time_we = 1'b1;
               if (ref_fifo_ff == TIER_FIFO) begin
                  scan_start = 1'b1;
                  state_in   = ST_DEMOTE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_DEMOTE: begin
            if (scan_res.done) begin
               if (scan_res.found) begin
                  tier_we  = 1'b1;
                  tier_wa  = scan_res.idx;
                  tier_wd  = TIER_FIFO;
                  order_we = 1'b1;
                  order_wa = scan_res.idx;
                  cnt_in   = cnt_ff + 1'b1;
               end
               state_in = (mode_ff == MODE_INSERT) ? ST_INS : ST_PROMO;
            end
         end
         ST_INS: begin
            tier_we  = 1'b1;
            tier_wd  = ins_tier_ff;
            order_we = 1'b1;
            crf_we   = 1'b1;
            time_we  = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            valid_in[slot_ff] = 1'b1;
            if (occ_ff > cap_ff) begin
               scan_start = 1'b1;
               scan_kind  = TIER_FIFO;
               state_in   = ST_EV_FIFO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_PROMO: begin
            tier_we  = 1'b1;
            order_we = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_OUT;
         end
         ST_EV_FIFO, ST_EV_PROT: begin
            if (scan_res.done) begin
               if (scan_res.found) begin
                  valid_in[scan_res.idx] = 1'b0;
                  occ_in      = occ_dec;
                  res_ev_in   = 1'b1;
                  res_slot_in = scan_res.idx;
                  res_last_in = !(occ_dec > cap_ff) || (occ_dec == '0);
                  state_in    = ST_OUT;
               end else if (state_ff == ST_EV_FIFO) begin
                  scan_start = 1'b1;
                  state_in   = ST_EV_PROT;
               end else begin
                  res_ev_in   = 1'b0;
                  res_slot_in = '0;
                  res_last_in = 1'b1;
                  state_in    = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_st_ff, res_slot_ff, res_ev_ff};
               rsp_tlast_in  = res_last_ff;
               if (res_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  scan_start = 1'b1;
                  scan_kind  = TIER_FIFO;
                  state_in   = ST_EV_FIFO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         cap_ff        <= 7'd64;
         thr_ff        <= 7'd7;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAP: cap_ff <= csr_data;
               CSR_THR: thr_ff <= csr_data;
               default: ;
            endcase
         end
      end
      mode_ff      <= mode_in;
      slot_ff      <= slot_in;
      now_ff       <= now_in;
      ins_tier_ff  <= ins_tier_in;
      ref_fifo_ff  <= ref_fifo_in;
      res_ev_ff    <= res_ev_in;
      res_slot_ff  <= res_slot_in;
      res_st_ff    <= res_st_in;
      res_last_ff  <= res_last_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   // entry memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (tier_we) tier_mem[tier_wa] <= tier_wd;
      if (order_we) order_mem[order_wa] <= cnt_ff;
      if (crf_we) crf_mem[slot_ff] <= crf_wd;
      if (time_we) time_mem[slot_ff] <= now_ff;
      tier_rd_ff  <= tier_mem[mem_addr];
      order_rd_ff <= order_mem[mem_addr];
      crf_rd_ff   <= crf_mem[mem_addr];
      time_rd_ff  <= time_mem[mem_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   // occupancy matches the number of valid slots between requests
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_ff) == int'(occ_ff)))
      else $error("occupancy out of step with valid bits");

   // occupancy never exceeds the slot count
   a_occ_max: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= ENTRIES)
      else $error("occupancy above slot count");

   // an eviction result never carries the ignored status
   a_evict_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> !rsp_tdata[7])
      else $error("eviction marked as ignored");

   // an ignored request gives a single closing result
   a_ignore_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7]) |-> rsp_tlast)
      else $error("ignored request result not last");
`endif

endmodule
`default_nettype wire

// File: verif/tb_lrfu_cache_replacement_core.sv
// Self-checking testbench for the LRFU cache replacement core.
`timescale 1ns / 1ps
module tb_lrfu_cache_replacement_core;
   import lrfu_pkg::*;

   localparam logic REG_CAPACITY  = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;
   localparam logic [1:0] MODE_BAD = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  slot;
      logic [31:0] now;
   } lru_req_type;

   typedef struct packed {
      logic       evict_valid;
      logic [5:0] evict_slot;
      logic       status;
      logic       last;
   } lru_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_data = '0;

   lrfu_cache_replacement_core uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the replacement state
   logic [16:0] decay_lut [256];
   logic        sh_valid [64];
   logic        sh_tier  [64];
   logic [23:0] sh_crf   [64];
   logic [31:0] sh_time  [64];
   logic [31:0] sh_order [64];
   logic [6:0]  sh_occ;
   logic [31:0] sh_counter;
   logic [6:0]  sh_cap;
   logic [6:0]  sh_thr;

   lru_req_type pending_reqs [$];
   lru_rsp_type expected_rsps [$];
   int  fail_count = 0;
   int  req_count = 0;
   int  rsp_count = 0;
   int  evict_count = 0;
   bit  idle_on = 1'b1;
   int  quiet_cycles = 0;

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         b = r | (64'd1 << i);
         if (b * b <= v && b < 64'h1_0000_0000) r = b;
      end
      return r;
   endfunction

   task automatic init_decay_lut();
      logic [63:0] roots [9];
      logic [63:0] t;
      roots[1] = sqrt_floor(64'd1 << 63);
      for (int m = 1; m < 8; m++) roots[m+1] = sqrt_floor(roots[m] << 32);
      for (int j = 0; j < 256; j++) begin
         t = 64'd1 << 32;
         for (int i = 0; i < 8; i++)
            if (j[i]) t = (t * roots[8-i] + (64'd1 << 31)) >> 32;
         t = (t + 64'd32768) >> 16;
         decay_lut[j] = t[16:0];
      end
   endtask

   function automatic int lowest_crf_slot();
      int best = -1;
      for (int i = 0; i < 64; i++) begin
         if (!sh_valid[i] || sh_tier[i] != TIER_PROT) continue;
         if (best < 0 || sh_crf[i] < sh_crf[best] ||
             (sh_crf[i] == sh_crf[best] &&
              sh_counter - sh_order[i] > sh_counter - sh_order[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic int fifo_front_slot();
      int best = -1;
      for (int i = 0; i < 64; i++) begin
         if (!sh_valid[i] || sh_tier[i] != TIER_FIFO) continue;
         if (best < 0 || sh_counter - sh_order[i] > sh_counter - sh_order[best])
            best = i;
      end
      return best;
   endfunction

   task automatic demote_lowest();
      int v;
      v = lowest_crf_slot();
      if (v >= 0) begin
         sh_tier[v]  = TIER_FIFO;
         sh_order[v] = sh_counter;
         sh_counter++;
      end
   endtask

   task automatic push_rsp(input logic ev, input logic [5:0] s, input logic st,
                           input logic lst);
      expected_rsps.push_back('{ev, s, st, lst});
   endtask

   // apply one accepted request and queue the results it causes
   task automatic predict_evictions(input lru_req_type r);
      int s, v, n, q;
      logic [31:0] dt, k, f, j;
      logic [63:0] d;
      s = r.slot;
      n = 0;
      if (r.mode == MODE_BAD || (r.mode == MODE_INSERT && sh_valid[s]) ||
          (r.mode != MODE_INSERT && !sh_valid[s])) begin
         push_rsp(1'b0, 6'd0, 1'b1, 1'b1);
         return;
      end
      if (r.mode == MODE_INSERT) begin
         sh_occ++;
         if ({1'b0, sh_occ} == {1'b0, sh_cap} + 8'd1) begin
            demote_lowest();
            sh_tier[s] = TIER_PROT;
         end else begin
            sh_tier[s] = (sh_occ > sh_thr) ? TIER_FIFO : TIER_PROT;
         end
         sh_valid[s] = 1'b1;
         sh_crf[s]   = CRF_ONE;
         sh_time[s]  = r.now;
         sh_order[s] = sh_counter;
         sh_counter++;
         q = expected_rsps.size();
         while (sh_occ > sh_cap && sh_occ > 0) begin
            v = fifo_front_slot();
            if (v < 0) v = lowest_crf_slot();
            if (v < 0) break;
            sh_valid[v] = 1'b0;
            sh_occ--;
            push_rsp(1'b1, v[5:0], 1'b0, 1'b0);
            n++;
            evict_count++;
         end
         if (n == 0) push_rsp(1'b0, 6'd0, 1'b0, 1'b1);
         else expected_rsps[q + n - 1].last = 1'b1;
      end else if (r.mode == MODE_REF) begin
         dt = r.now - sh_time[s];
         k  = dt / DECAY_PERIOD;
         f  = dt % DECAY_PERIOD;
         j  = (f << 8) / DECAY_PERIOD;
         d  = (64'(sh_crf[s]) * decay_lut[j[7:0]]) >> 16;
         d  = (k >= 24) ? 64'd0 : (d >> k);
         d  = d + CRF_ONE;
         sh_crf[s]  = (d > CRF_MAX) ? CRF_MAX : d[23:0];
         sh_time[s] = r.now;
         if (sh_tier[s] == TIER_FIFO) begin
            demote_lowest();
            sh_tier[s]  = TIER_PROT;
            sh_order[s] = sh_counter;
            sh_counter++;
         end
         push_rsp(1'b0, 6'd0, 1'b0, 1'b1);
      end else begin
         sh_valid[s] = 1'b0;
         if (sh_occ > 0) sh_occ--;
         push_rsp(1'b0, 6'd0, 1'b0, 1'b1);
      end
   endtask

   // request driver: one item per handshake, a random gap between items while idle_on is set
   int req_gap = 0;
   int req_seen = 0;
   always @(negedge clock) begin
      lru_req_type r;
      logic        v_next;
      if (!reset && !(req_tvalid && req_seen == req_count)) begin
         req_seen = req_count;
         v_next = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_tdata <= {r.now, r.slot, r.mode};
            v_next = 1'b1;
            req_gap = idle_on ? $urandom_range(0, 5) : 0;
         end
         req_tvalid <= v_next;
      end
   end

   // result ready: stall drawn per result
   int rsp_gap = 0;
   int rsp_seen = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            rsp_gap = idle_on ? $urandom_range(0, 5) : 0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: check results, then feed accepted requests to the predictor
   always @(posedge clock) begin
      lru_rsp_type act;
      lru_rsp_type exp_r;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            rsp_count++;
            act = '{rsp_tdata[0], rsp_tdata[6:1], rsp_tdata[7], rsp_tlast};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, act);
               fail_count++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (act.evict_valid !== exp_r.evict_valid ||
                   act.evict_slot !== exp_r.evict_slot ||
                   act.status !== exp_r.status || act.last !== exp_r.last) begin
                  $display("%0t: mismatch valid/slot/status/last expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                           $time, exp_r.evict_valid, exp_r.evict_slot, exp_r.status,
                           exp_r.last, act.evict_valid, act.evict_slot, act.status,
                           act.last);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            req_count++;
            predict_evictions('{req_tdata[1:0], req_tdata[7:2], req_tdata[39:8]});
         end
         if (csr_valid && csr_ready) quiet_cycles = 0;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_rsps.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_CAPACITY) sh_cap = val;
      else sh_thr = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_req(input logic [1:0] m, input int s, input logic [31:0] t);
      pending_reqs.push_back('{m, s[5:0], t});
   endtask

   // random traffic: inserts dominate so the tiers fill and evictions happen
   task automatic add_random(input int count, input int hot);
      logic [31:0] t;
      int p;
      t = $urandom;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(0, 99);
         if (p < 3) t = $urandom;
         else if (p < 8) t = t + $urandom_range(100000, 400000);
         else t = t + $urandom_range(0, 25000);
         p = $urandom_range(0, 99);
         add_req(p < 50 ? MODE_INSERT : p < 82 ? MODE_REF : p < 96 ? MODE_ERASE : MODE_BAD,
                 $urandom_range(0, hot), t);
      end
   endtask

   initial begin
      init_decay_lut();
      for (int i = 0; i < 64; i++) sh_valid[i] = 1'b0;
      sh_occ = 0;
      sh_counter = 0;
      sh_cap = 7'd64;
      sh_thr = 7'd7;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: ignored cases, decay corners, promotion out of the FIFO tier
      add_req(MODE_INSERT, 0, 32'd0);
      add_req(MODE_INSERT, 63, 32'd0);
      add_req(MODE_INSERT, 0, 32'd1);
      add_req(MODE_REF, 5, 32'd2);
      add_req(MODE_ERASE, 5, 32'd2);
      add_req(MODE_BAD, 0, 32'd3);
      add_req(MODE_REF, 0, 32'd10000);
      add_req(MODE_REF, 0, 32'd10001);
      add_req(MODE_REF, 0, 32'd5000);
      add_req(MODE_REF, 63, 32'hFFFF_FFFF);
      for (int i = 1; i <= 8; i++) add_req(MODE_INSERT, i, 32'd20000 + i);
      add_req(MODE_REF, 8, 32'd29999);
      add_req(MODE_REF, 8, 32'd29999);
      add_req(MODE_ERASE, 63, 32'hAAAA_5555);
      add_req(MODE_ERASE, 1, 32'h5555_AAAA);
      wait_idle();

      // shrink the cache so the pending inserts force evictions
      write_reg(REG_CAPACITY, 7'd3);
      add_req(MODE_INSERT, 40, 32'd50000);
      add_req(MODE_INSERT, 41, 32'd50001);
      wait_idle();

      begin
         logic [6:0] caps [7] = '{7'd4, 7'd1, 7'd0, 7'd127, 7'd16, 7'd64, 7'd8};
         logic [6:0] thrs [7] = '{7'd2, 7'd0, 7'd0, 7'd127, 7'd64, 7'd7, 7'd3};
         int hots [7] = '{15, 7, 7, 63, 31, 63, 23};
         for (int ph = 0; ph < 7; ph++) begin
            idle_on = (ph != 4);
            write_reg(REG_CAPACITY, caps[ph]);
            write_reg(REG_THRESHOLD, thrs[ph]);
            add_random(52, hots[ph]);
            wait_idle();
         end
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d requests and %0d results (%0d evictions) over nine cache settings.",
               req_count, rsp_count, evict_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/lrfu_pkg.sv
rtl/lrfu_decay.sv
rtl/lrfu_scan.sv
rtl/lrfu_cache_replacement_core.sv
verif/tb_lrfu_cache_replacement_core.sv
